// File: hw/rtl/tme_pkg.sv
`default_nettype none
package tme_pkg;

    localparam int RULE_SLOTS = 64;
    localparam int TAPE_CELLS = 128;
    localparam int RI_W       = $clog2(RULE_SLOTS);
    localparam int RC_W       = $clog2(RULE_SLOTS + 1);
    localparam int TAPE_AW    = $clog2(TAPE_CELLS);
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    // decoded operations
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_STEP  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_NOP   = 3'd5;

    localparam logic [1:0] KIND_LEFT  = 2'd0;
    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_HALT  = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_STEPPED = 3'd1;
    localparam logic [2:0] ST_NORULE  = 3'd2;
    localparam logic [2:0] ST_ACCEPT  = 3'd3;
    localparam logic [2:0] ST_REJECT  = 3'd4;
    localparam logic [2:0] ST_BADDIR  = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    localparam logic CFG_INIT_STATE = 1'b0;
    localparam logic CFG_INIT_HEAD  = 1'b1;

    typedef struct packed {
        logic [9:0] state;
        logic [7:0] rd;
        logic [7:0] wr;
        logic [1:0] kind;
        logic       accept;
        logic [9:0] next;
    } t_rule;

    typedef struct packed {
        logic [2:0] op;
        t_rule      rule;
        logic [6:0] cell_index;
        logic [7:0] cell_symbol;
    } t_cmd;

endpackage
`default_nettype wire

// File: hw/rtl/turing_machine_step_engine.sv
`default_nettype none
// Single-tape Turing machine step engine. Words enter through a two-deep
// command queue and each produces one result word. A step on a halted machine
// scans no rules; any other step scans the loaded rules in order up to the
// first match (all loaded rules when none matches) through the rule memory's
// single read port, which delivers one entry per cycle. Tape cells never
// written read as 255.
module turing_machine_step_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [2:0]  i_func,
    input  wire logic [9:0]  i_rule_state,
    input  wire logic [7:0]  i_rule_read_symbol,
    input  wire logic [7:0]  i_rule_write_symbol,
    input  wire logic [1:0]  i_rule_kind,
    input  wire logic        i_rule_accept,
    input  wire logic [9:0]  i_rule_next_state,
    input  wire logic [6:0]  i_cell_index,
    input  wire logic [7:0]  i_cell_symbol,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [2:0]       o_status,
    output logic [9:0]       o_machine_state,
    output logic [6:0]       o_head_position,
    output logic [5:0]       o_rule_matched,
    output logic [7:0]       o_read_symbol,
    output logic             o_cell_changed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);
    import tme_pkg::*;

    logic [9:0] r_init_state;
    logic [6:0] r_init_head;
    t_rule      rule;
    t_cmd       cmd;
    logic       cmd_valid, cmd_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_state <= '0;
            r_init_head  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INIT_STATE: r_init_state <= i_cfg_data;
                CFG_INIT_HEAD:  r_init_head  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign rule = '{state: i_rule_state, rd: i_rule_read_symbol, wr: i_rule_write_symbol,
                    kind: i_rule_kind, accept: i_rule_accept, next: i_rule_next_state};

    tme_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_func,
        .i_rule(rule), .i_cell_index, .i_cell_symbol,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    tme_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .i_init_state(r_init_state), .i_init_head(r_init_head),
        .o_empty, .i_pop, .o_status, .o_machine_state, .o_head_position,
        .o_rule_matched, .o_read_symbol, .o_cell_changed
    );

endmodule
`default_nettype wire

// File: hw/rtl/tme_front.sv
`default_nettype none
module tme_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire logic [2:0]      i_func,
    input  wire tme_pkg::t_rule  i_rule,
    input  wire logic [6:0]      i_cell_index,
    input  wire logic [7:0]      i_cell_symbol,
    output logic                 o_cmd_valid,
    output tme_pkg::t_cmd        o_cmd,
    input  wire logic            i_cmd_take
);
    import tme_pkg::*;

    t_cmd              r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic [2:0]        op;
    logic              wr_en, rd_en;

    always_comb begin
        unique case (i_func)
            3'd0:    op = OP_LOAD;
            3'd1:    op = OP_WRITE;
            3'd2:    op = OP_START;
            3'd3:    op = OP_STEP;
            3'd4:    op = OP_READ;
            default: op = OP_NOP;
        endcase
    end

    assign o_full      = (r_cnt == Q_CW'(Q_DEPTH));
    assign wr_en       = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign rd_en       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= '{op: op, rule: i_rule, cell_index: i_cell_index,
                           cell_symbol: i_cell_symbol};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (rd_en) r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + Q_CW'(wr_en) - Q_CW'(rd_en);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tme_back.sv
`default_nettype none
module tme_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire tme_pkg::t_cmd   i_cmd,
    output logic                 o_cmd_take,
    input  wire logic [9:0]      i_init_state,
    input  wire logic [6:0]      i_init_head,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output logic [2:0]           o_status,
    output logic [9:0]           o_machine_state,
    output logic [6:0]           o_head_position,
    output logic [5:0]           o_rule_matched,
    output logic [7:0]           o_read_symbol,
    output logic                 o_cell_changed
);
    import tme_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TWAIT = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    t_rule              rule_mem [RULE_SLOTS];
    logic [7:0]         tape_mem [TAPE_CELLS];
    logic [TAPE_CELLS-1:0] r_tvalid;

    logic [2:0]         r_fsm;
    t_cmd               r_cmd;
    t_rule              r_rule, rule_q;
    logic [7:0]         r_tq;
    logic               r_tvq;
    logic [RC_W-1:0]    r_rcnt, r_issue;
    logic               r_pend;
    logic [RI_W-1:0]    r_pidx;
    logic [9:0]         r_state;
    logic [6:0]         r_head;
    logic               r_halted;
    logic [7:0]         r_sym;
    logic [2:0]         r_res_status;
    logic [5:0]         r_res_idx;
    logic [7:0]         r_res_sym;
    logic               r_res_chg;
    logic               r_ov;

    logic               tape_we;
    logic [TAPE_AW-1:0] tape_wa, tape_ra;
    logic [7:0]         tape_wd, sym;
    logic               match, out_free;

    assign sym      = r_tvq ? r_tq : 8'hFF;
    assign match    = r_pend && (rule_q.state == r_state) &&
                      ((rule_q.rd == r_sym) || (rule_q.kind == KIND_HALT));
    assign out_free = !r_ov || i_pop;
    assign o_cmd_take = (r_fsm == S_IDLE);

    always_comb begin
        tape_we = 1'b0;
        tape_wa = i_cmd.cell_index[TAPE_AW-1:0];
        tape_wd = i_cmd.cell_symbol;
        tape_ra = r_head[TAPE_AW-1:0];
        if (r_fsm == S_IDLE && i_cmd_valid) begin
            if (i_cmd.op == OP_WRITE && 32'(i_cmd.cell_index) < TAPE_CELLS) tape_we = 1'b1;
            if (i_cmd.op == OP_READ) tape_ra = i_cmd.cell_index[TAPE_AW-1:0];
        end
        if (r_fsm == S_EXEC && r_rule.kind != KIND_HALT) begin
            tape_we = 1'b1;
            tape_wa = r_head[TAPE_AW-1:0];
            tape_wd = r_rule.wr;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (tape_we) tape_mem[tape_wa] <= tape_wd;
        r_tq   <= tape_mem[tape_ra];
        rule_q <= rule_mem[r_issue[RI_W-1:0]];
        if (r_fsm == S_IDLE && i_cmd_valid && i_cmd.op == OP_LOAD &&
            32'(r_rcnt) < RULE_SLOTS) begin
            rule_mem[r_rcnt[RI_W-1:0]] <= i_cmd.rule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
            r_tvq    <= 1'b0;
        end else begin
            if (tape_we) r_tvalid[tape_wa] <= 1'b1;
            r_tvq <= r_tvalid[tape_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_rcnt   <= '0;
            r_issue  <= '0;
            r_pend   <= 1'b0;
            r_state  <= '0;
            r_head   <= '0;
            r_halted <= 1'b1;
            r_ov     <= 1'b0;
        end else begin
            if (i_pop && r_ov) r_ov <= 1'b0;
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd        <= i_cmd;
                        r_res_status <= ST_DONE;
                        r_res_idx    <= '0;
                        r_res_sym    <= '0;
                        r_res_chg    <= 1'b0;
                        r_fsm        <= S_EMIT;
                        case (i_cmd.op)
                            OP_LOAD: begin
                                if (32'(r_rcnt) < RULE_SLOTS) r_rcnt <= r_rcnt + 1'b1;
                                else r_res_status <= ST_FULL;
                            end
                            OP_START: begin
                                r_state  <= i_init_state;
                                r_head   <= (32'(i_init_head) < TAPE_CELLS) ? i_init_head
                                            : 7'(TAPE_CELLS - 1);
                                r_halted <= 1'b0;
                            end
                            OP_STEP, OP_READ: r_fsm <= S_TWAIT;
                            default: ;
                        endcase
                    end
                end
                S_TWAIT: begin
                    if (r_cmd.op == OP_READ) begin
                        r_res_sym <= (32'(r_cmd.cell_index) < TAPE_CELLS) ? sym : 8'd0;
                        r_fsm     <= S_EMIT;
                    end else begin
                        r_sym     <= sym;
                        r_res_sym <= sym;
                        r_issue   <= '0;
                        r_pend    <= 1'b0;
                        r_fsm     <= r_halted ? S_EMIT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one rule read issued per cycle, compared the next
                    if (match) begin
                        r_rule <= rule_q;
                        r_res_idx <= 6'(r_pidx);
                        r_fsm  <= S_EXEC;
                    end else if (!r_pend && r_issue >= r_rcnt) begin
                        r_halted     <= 1'b1;
                        r_res_status <= ST_NORULE;
                        r_fsm        <= S_EMIT;
                    end else if (r_issue < r_rcnt) begin
                        r_pend  <= 1'b1;
                        r_pidx  <= r_issue[RI_W-1:0];
                        r_issue <= r_issue + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_fsm <= S_EMIT;
                    if (r_rule.kind == KIND_HALT) begin
                        r_halted     <= 1'b1;
                        r_res_status <= r_rule.accept ? ST_ACCEPT : ST_REJECT;
                    end else begin
                        r_res_chg    <= (r_sym != r_rule.wr);
                        r_state      <= r_rule.next;
                        r_res_status <= ST_STEPPED;
                        case (r_rule.kind)
                            KIND_LEFT:  if (r_head != '0) r_head <= r_head - 1'b1;
                            KIND_RIGHT: if (32'(r_head) + 1 < TAPE_CELLS) r_head <= r_head + 1'b1;
                            default: begin
                                r_halted     <= 1'b1;
                                r_res_status <= ST_BADDIR;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov  <= 1'b1;
                        r_fsm <= S_IDLE;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_EMIT && out_free) begin
            o_status        <= r_res_status;
            o_machine_state <= r_state;
            o_head_position <= r_head;
            o_rule_matched  <= r_res_idx;
            o_read_symbol   <= r_res_sym;
            o_cell_changed  <= r_res_chg;
        end
    end

    assign o_empty = !r_ov;

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rcnt) <= RULE_SLOTS) else $error("rule count overflow");
    a_norule_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_SCAN && !match && !r_pend && r_issue >= r_rcnt) |=> r_halted)
        else $error("no-rule step did not halt");
    a_exec_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EXEC) |=> (r_fsm == S_EMIT)) else $error("exec not followed by emit");

endmodule
`default_nettype wire

// File: tb/sv/tb_turing_machine_step_engine.sv
`timescale 1ns / 1ps
module tb_turing_machine_step_engine;
    import tme_pkg::*;

    typedef struct {
        logic [2:0] status;
        logic [9:0] mstate;
        logic [6:0] head;
        logic [5:0] matched;
        logic [7:0] rsym;
        logic       changed;
    } tm_result_t;

    localparam int CMD_W = $bits(t_cmd);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [2:0]  i_func;
    logic [9:0]  i_rule_state;
    logic [7:0]  i_rule_read_symbol;
    logic [7:0]  i_rule_write_symbol;
    logic [1:0]  i_rule_kind;
    logic        i_rule_accept;
    logic [9:0]  i_rule_next_state;
    logic [6:0]  i_cell_index;
    logic [7:0]  i_cell_symbol;
    logic        o_empty;
    logic        i_pop;
    logic [2:0]  o_status;
    logic [9:0]  o_machine_state;
    logic [6:0]  o_head_position;
    logic [5:0]  o_rule_matched;
    logic [7:0]  o_read_symbol;
    logic        o_cell_changed;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [9:0]  i_cfg_data;

    turing_machine_step_engine DUT (.*);

    // machine image kept by the testbench
    t_rule       rules_m [RULE_SLOTS];
    int          rule_cnt_m;
    logic [7:0]  tape_m [TAPE_CELLS];
    logic [9:0]  state_m;
    logic [6:0]  head_m;
    bit          halted_m;
    logic [9:0]  init_state_m;
    logic [6:0]  init_head_m;

    tm_result_t  pending_results[$];
    int          errors;
    int          words_sent;
    int          words_checked;
    int          steps_sent;
    longint      cycles;
    bit          no_idle;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, checked against oldest expectation
    always @(posedge i_clk) begin
        tm_result_t e;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result word, status %0d", $time, o_status);
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    words_checked++;
                    if (e.status !== o_status) begin
                        $display("%0t status: expected %0d actual %0d", $time, e.status, o_status);
                        errors++;
                    end
                    if (e.mstate !== o_machine_state) begin
                        $display("%0t machine_state: expected %0d actual %0d",
                                 $time, e.mstate, o_machine_state);
                        errors++;
                    end
                    if (e.head !== o_head_position) begin
                        $display("%0t head_position: expected %0d actual %0d",
                                 $time, e.head, o_head_position);
                        errors++;
                    end
                    if (e.matched !== o_rule_matched) begin
                        $display("%0t rule_matched: expected %0d actual %0d",
                                 $time, e.matched, o_rule_matched);
                        errors++;
                    end
                    if (e.rsym !== o_read_symbol) begin
                        $display("%0t read_symbol: expected %0d actual %0d",
                                 $time, e.rsym, o_read_symbol);
                        errors++;
                    end
                    if (e.changed !== o_cell_changed) begin
                        $display("%0t cell_changed: expected %0d actual %0d",
                                 $time, e.changed, o_cell_changed);
                        errors++;
                    end
                end
            end
        end
        i_pop <= no_idle || ($urandom_range(99) >= 28);
    end

    task automatic tm_apply(input t_cmd c);
        tm_result_t r;
        logic [7:0] sym;
        int         k;
        int         hit;
        r = '{status: ST_DONE, mstate: 0, head: 0, matched: 0, rsym: 0, changed: 0};
        case (c.op)
            OP_LOAD: begin
                if (rule_cnt_m >= RULE_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    rules_m[rule_cnt_m] = c.rule;
                    rule_cnt_m++;
                end
            end
            OP_WRITE: tape_m[c.cell_index] = c.cell_symbol;
            OP_START: begin
                state_m  = init_state_m;
                head_m   = init_head_m;
                halted_m = 0;
            end
            OP_STEP: begin
                sym    = tape_m[head_m];
                r.rsym = sym;
                if (!halted_m) begin
                    hit = -1;
                    for (k = 0; k < rule_cnt_m && hit < 0; k++)
                        if (rules_m[k].state == state_m &&
                            (rules_m[k].rd == sym || rules_m[k].kind == KIND_HALT))
                            hit = k;
                    if (hit < 0) begin
                        halted_m = 1;
                        r.status = ST_NORULE;
                    end else begin
                        r.matched = hit[5:0];
                        if (rules_m[hit].kind == KIND_HALT) begin
                            halted_m = 1;
                            r.status = rules_m[hit].accept ? ST_ACCEPT : ST_REJECT;
                        end else begin
                            r.changed = (sym != rules_m[hit].wr);
                            tape_m[head_m] = rules_m[hit].wr;
                            state_m = rules_m[hit].next;
                            r.status = ST_STEPPED;
                            if (rules_m[hit].kind == KIND_LEFT) begin
                                if (head_m != 0) head_m--;
                            end else if (rules_m[hit].kind == KIND_RIGHT) begin
                                if (head_m != TAPE_CELLS - 1) head_m++;
                            end else begin
                                halted_m = 1;
                                r.status = ST_BADDIR;
                            end
                        end
                    end
                end
            end
            OP_READ: r.rsym = tape_m[c.cell_index];
            default: ;
        endcase
        r.mstate = state_m;
        r.head   = head_m;
        pending_results.push_back(r);
    endtask

    task automatic send_word(input t_cmd c);
        int gap;
        if (!no_idle && $urandom_range(99) < 28) begin
            i_push <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        i_push              <= 1'b1;
        i_func              <= c.op;
        i_rule_state        <= c.rule.state;
        i_rule_read_symbol  <= c.rule.rd;
        i_rule_write_symbol <= c.rule.wr;
        i_rule_kind         <= c.rule.kind;
        i_rule_accept       <= c.rule.accept;
        i_rule_next_state   <= c.rule.next;
        i_cell_index        <= c.cell_index;
        i_cell_symbol       <= c.cell_symbol;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        tm_apply(c);
        words_sent++;
        if (c.op == OP_STEP) steps_sent++;
    endtask

    function automatic t_cmd rand_word();
        t_cmd c;
        c = CMD_W'({$urandom, $urandom});
        return c;
    endfunction

    function automatic t_cmd mk_word(input logic [2:0] op, input logic [6:0] idx = 0,
                                     input logic [7:0] sym = 0);
        t_cmd c;
        c = rand_word();
        c.op = op;
        c.cell_index = idx;
        c.cell_symbol = sym;
        return c;
    endfunction

    function automatic t_cmd mk_rule(input logic [9:0] st, input logic [7:0] rd,
                                     input logic [7:0] wr, input logic [1:0] kind,
                                     input logic acc, input logic [9:0] nxt);
        t_cmd c;
        c = rand_word();
        c.op = OP_LOAD;
        c.rule = '{state: st, rd: rd, wr: wr, kind: kind, accept: acc, next: nxt};
        return c;
    endfunction

    // quiesce the input side, then write one register
    task automatic write_cfg(input logic idx, input logic [9:0] val);
        i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_INIT_STATE) init_state_m = val;
        else init_head_m = val[6:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        write_cfg(CFG_INIT_STATE, 10'd0);
        write_cfg(CFG_INIT_HEAD, 10'h3FF);      // upper bits dropped: head 127
        send_word(mk_word(OP_READ, 7'd127));
        send_word(mk_word(OP_STEP));            // halted since reset
        send_word(mk_word(OP_WRITE, 7'd127, 8'd0));
        send_word(mk_word(OP_WRITE, 7'd0, 8'd255));
        send_word(mk_rule(10'd1023, 8'd0, 8'd255, KIND_RIGHT, 1'b1, 10'd1023));
        send_word(mk_rule(10'd0, 8'd0, 8'd170, KIND_RIGHT, 1'b0, 10'd1));
        send_word(mk_rule(10'd1, 8'd170, 8'd85, KIND_LEFT, 1'b1, 10'd2));
        send_word(mk_rule(10'd2, 8'd255, 8'd255, KIND_BAD, 1'b0, 10'd3));
        send_word(mk_rule(10'd3, 8'd9, 8'd9, KIND_HALT, 1'b1, 10'd0));
        send_word(mk_rule(10'd4, 8'd9, 8'd9, KIND_HALT, 1'b0, 10'd0));
        send_word(mk_word(OP_START));
        send_word(mk_word(OP_STEP));            // right, clamped at the top cell
        send_word(mk_word(OP_STEP));            // left
        send_word(mk_word(OP_STEP));            // bad direction, same symbol
        send_word(mk_word(OP_STEP));            // halted
        send_word(mk_word(OP_READ, 7'd127));
        send_word(mk_word(3'd5));
        send_word(mk_word(3'd6));
        send_word(mk_word(3'd7));
        write_cfg(CFG_INIT_STATE, 10'd3);
        write_cfg(CFG_INIT_HEAD, 10'd0);
        send_word(mk_word(OP_START));
        send_word(mk_word(OP_STEP));            // accept halt
        write_cfg(CFG_INIT_STATE, 10'd4);
        send_word(mk_word(OP_START));
        send_word(mk_word(OP_STEP));            // reject halt
        write_cfg(CFG_INIT_STATE, 10'd1);
        send_word(mk_word(OP_START));
        send_word(mk_word(OP_STEP));            // no rule
        write_cfg(CFG_INIT_STATE, 10'd1023);
        send_word(mk_word(OP_START));
        send_word(mk_word(OP_STEP));            // no rule: cell 0 holds 255, not 0
    endtask

    function automatic t_cmd rand_machine_rule();
        t_cmd c;
        int   p;
        c = rand_word();
        c.op = OP_LOAD;
        if ($urandom_range(9) != 0) begin
            c.rule.state = 10'($urandom_range(5));
            c.rule.next  = 10'($urandom_range(5));
            c.rule.rd    = 8'($urandom_range(3));
            c.rule.wr    = 8'($urandom_range(3));
        end
        p = $urandom_range(99);
        c.rule.kind = p < 42 ? KIND_LEFT : p < 84 ? KIND_RIGHT : p < 94 ? KIND_HALT : KIND_BAD;
        return c;
    endfunction

    task automatic test_load_program();
        repeat (44) send_word(rand_machine_rule());
    endtask

    task automatic test_table_full();
        while (rule_cnt_m < RULE_SLOTS) send_word(rand_machine_rule());
        repeat (3) send_word(rand_machine_rule());
    endtask

    task automatic run_random(input int n);
        t_cmd c;
        int   p;
        repeat (n) begin
            p = $urandom_range(99);
            c = rand_word();
            if (p < 8) c.op = OP_START;
            else if (p < 76) c.op = OP_STEP;
            else if (p < 86) begin
                c.op = OP_WRITE;
                if ($urandom_range(3) != 0) c.cell_symbol = 8'($urandom_range(3));
            end else if (p < 94) c.op = OP_READ;
            else if (p < 97) c.op = OP_LOAD;
            else c.op = 3'($urandom_range(5, 7));
            send_word(c);
        end
    endtask

    task automatic test_random_runs();
        int ph;
        for (ph = 0; ph < 10; ph++) begin
            no_idle = (ph == 4);
            case (ph)
                0: write_cfg(CFG_INIT_HEAD, 10'd127);
                1: write_cfg(CFG_INIT_HEAD, 10'd0);
                default: write_cfg(CFG_INIT_HEAD, 10'($urandom));
            endcase
            if (ph == 7) write_cfg(CFG_INIT_STATE, 10'd1023);
            else write_cfg(CFG_INIT_STATE, ph == 8 ? 10'($urandom) : 10'($urandom_range(5)));
            run_random(180);
        end
        no_idle = 0;
    endtask

    initial begin
        errors = 0; words_sent = 0; words_checked = 0; steps_sent = 0;
        no_idle = 0;
        rule_cnt_m = 0; state_m = 0; head_m = 0; halted_m = 1;
        init_state_m = 0; init_head_m = 0;
        foreach (tape_m[k]) tape_m[k] = 8'hFF;
        i_rst_n <= 1'b0;
        i_push <= 1'b0;
        i_func <= '0;
        i_rule_state <= '0;
        i_rule_read_symbol <= '0;
        i_rule_write_symbol <= '0;
        i_rule_kind <= '0;
        i_rule_accept <= 1'b0;
        i_rule_next_state <= '0;
        i_cell_index <= '0;
        i_cell_symbol <= '0;
        i_pop <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_load_program();
        run_random(60);
        test_table_full();
        test_random_runs();

        i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d words (%0d steps) and checked %0d results;", words_sent, steps_sent,
                 words_checked);
        $display("rule table filled to %0d entries, %0d mismatches.", rule_cnt_m, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/tme_pkg.sv
hw/rtl/tme_front.sv
hw/rtl/tme_back.sv
hw/rtl/turing_machine_step_engine.sv
tb/sv/tb_turing_machine_step_engine.sv
